[sv/hslc_pkg.sv]
// ----------------------------------------------------------------------------
// hslc_pkg: shared definitions for the hashed set-associative id cache
// Geometry, field widths, the per-entry metadata word and the sequencer
// state type used by the hash unit and the top level.
// ----------------------------------------------------------------------------
package hslc_pkg;

  // Cache geometry (both counts are powers of two)
  localparam int unsigned SET_COUNT   = 64;
  localparam int unsigned WAY_COUNT   = 16;
  localparam int unsigned SET_BITS    = $clog2(SET_COUNT);
  localparam int unsigned WAY_BITS    = $clog2(WAY_COUNT);
  localparam int unsigned ENTRY_COUNT = SET_COUNT * WAY_COUNT;

  // Transaction field widths
  localparam int unsigned ID_WIDTH      = 64;
  localparam int unsigned HANDLE_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned SET_NUM_WIDTH = 6;

  // Byte-serial hash: h = 33*h + byte, least significant byte first
  localparam int unsigned BYTE_WIDTH    = 8;
  localparam int unsigned BYTE_SHIFT    = $clog2(BYTE_WIDTH);
  localparam int unsigned ID_BYTES      = ID_WIDTH / BYTE_WIDTH;
  localparam int unsigned BYTE_SEL_BITS = $clog2(ID_BYTES);
  localparam int unsigned HASH_SHIFT    = 5;

  // Per-entry metadata: valid flag and recency rank (0 = most recent)
  typedef struct packed {
    logic                valid;
    logic [WAY_BITS-1:0] rank;
  } meta_t;

  // Hash unit status toward the sequencer
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SET_BITS-1:0] set_idx;
  } hash_stat_t;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_FILL,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

[sv/hslc_ram.sv]
// ----------------------------------------------------------------------------
// hslc_ram: generic single-write, single-read memory
// One write port and one read port per cycle; read data is registered.
// ----------------------------------------------------------------------------
module hslc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/hslc_hash.sv]
// ----------------------------------------------------------------------------
// hslc_hash: byte-serial set hash
// Folds one byte of the id per cycle through a shift-add unit (h*33 + b).
// Only the low set-index bits of h are kept, since the set is h mod SET_COUNT.
// ----------------------------------------------------------------------------
module hslc_hash (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [hslc_pkg::ID_WIDTH-1:0]  id,
  output hslc_pkg::hash_stat_t           stat
);
  import hslc_pkg::*;

  logic [SET_BITS-1:0]      h_r;
  logic [SET_BITS-1:0]      h_nxt;
  logic [BYTE_SEL_BITS-1:0] cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [BYTE_WIDTH-1:0]    byte_v;

  // Select the current byte, least significant first
  assign byte_v = id[{cnt_r, BYTE_SHIFT'(0)} +: BYTE_WIDTH];

  // Shared shift-add step: h*33 + byte, truncated to the set index
  assign h_nxt = h_r + (h_r << HASH_SHIFT) + SET_BITS'(byte_v);

  // Control: run one step per cycle for all id bytes, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BYTE_SEL_BITS'(ID_BYTES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      h_r <= '0;
    end else if (busy_r) begin
      h_r <= h_nxt;
    end
  end

  assign stat.busy    = busy_r;
  assign stat.done    = done_r;
  assign stat.set_idx = h_r;

endmodule

[sv/hashed_set_lru_id_cache.sv]
// ----------------------------------------------------------------------------
// hashed_set_lru_id_cache: 64-set, 16-way id cache with true LRU replacement
//
// Input channel (in_valid/in_ready): one transaction carries a 64-bit id and
// the handle the backing store returns for it. The id is hashed byte by byte
// (h = 33*h + byte) to a set. The set's ways are then scanned one per cycle
// through the tag, value and metadata memories; a hit returns the stored
// handle, a miss writes id and handle into the least recent way. A second
// one-way-per-cycle pass rewrites the recency ranks of the set.
// Result channel (out_valid/out_ready): hit flag, handle, eviction flag, set
// and the running hit, miss and eviction totals after this lookup.
// From input acceptance to out_valid a lookup runs the hash, the way scan,
// the fill, the rank update and the done state, in that order.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next lookup is taken while it waits, and that
// lookup holds in its done state until the receiver takes the earlier one.
// Reset clears counters, per-set row flags and control state; a set whose
// row flag is clear reads as all ways invalid with rank equal to way index,
// so no clearing pass over the memories is needed.
// ----------------------------------------------------------------------------
module hashed_set_lru_id_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hslc_pkg::ID_WIDTH-1:0]       in_lookup_id,
  input  logic [hslc_pkg::HANDLE_WIDTH-1:0]   in_fill_handle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [hslc_pkg::HANDLE_WIDTH-1:0]   out_value_handle,
  output logic                                out_evicted,
  output logic [hslc_pkg::SET_NUM_WIDTH-1:0]  out_set_number,
  output logic [hslc_pkg::COUNT_WIDTH-1:0]    out_hit_total,
  output logic [hslc_pkg::COUNT_WIDTH-1:0]    out_miss_total,
  output logic [hslc_pkg::COUNT_WIDTH-1:0]    out_evict_total
);
  import hslc_pkg::*;

  localparam int unsigned ADDR_BITS = $clog2(ENTRY_COUNT);
  localparam int unsigned META_BITS = $bits(meta_t);
  localparam logic [WAY_BITS:0]   CNT_END  = (WAY_BITS + 1)'(WAY_COUNT);
  localparam logic [WAY_BITS-1:0] RANK_LRU = WAY_BITS'(WAY_COUNT - 1);

  // Sequencer and lookup registers
  state_t                    state_r, state_nxt;
  logic [ID_WIDTH-1:0]       id_r;
  logic [HANDLE_WIDTH-1:0]   fill_r;
  logic [SET_BITS-1:0]       set_r;
  logic [WAY_BITS:0]         cnt_r;
  logic                      rd_vld_r;
  logic [WAY_BITS-1:0]       rd_way_r;
  logic                      found_r;
  logic [WAY_BITS-1:0]       hit_way_r;
  logic [WAY_BITS-1:0]       hit_rank_r;
  logic [HANDLE_WIDTH-1:0]   handle_r;
  logic [WAY_BITS-1:0]       vic_way_r;
  logic                      vic_valid_r;
  logic [SET_COUNT-1:0]      row_valid_r;

  // Counters and output register
  logic [COUNT_WIDTH-1:0]    hit_cnt_r;
  logic [COUNT_WIDTH-1:0]    miss_cnt_r;
  logic [COUNT_WIDTH-1:0]    evict_cnt_r;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [HANDLE_WIDTH-1:0]   out_handle_r;
  logic                      out_evicted_r;
  logic [SET_NUM_WIDTH-1:0]  out_set_r;

  // Combinational control
  logic                      in_fire;
  logic                      out_free;
  logic                      issue;
  logic                      finish;
  logic                      evict;
  logic                      row_ok;
  logic [WAY_BITS-1:0]       tgt_way;
  logic [WAY_BITS-1:0]       tgt_rank;
  hash_stat_t                hash_stat;

  // Memory ports
  logic [ADDR_BITS-1:0]      raddr;
  logic                      fill_we;
  logic [ADDR_BITS-1:0]      fill_addr;
  logic [ID_WIDTH-1:0]       tag_rdata;
  logic [HANDLE_WIDTH-1:0]   val_rdata;
  logic                      meta_we;
  logic [ADDR_BITS-1:0]      meta_waddr;
  meta_t                     meta_wdata;
  logic [META_BITS-1:0]      meta_rbits;
  meta_t                     meta_rd;
  meta_t                     meta_eff;

  // Byte-serial hash unit
  hslc_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .id    (id_r),
    .stat  (hash_stat)
  );

  // Tag, value and metadata memories, one entry per way of every set
  hslc_ram #(.WIDTH(ID_WIDTH), .DEPTH(ENTRY_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (id_r),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  hslc_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(ENTRY_COUNT)) u_val_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_r),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  hslc_ram #(.WIDTH(META_BITS), .DEPTH(ENTRY_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_rbits)
  );

  // Handshake
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Way walk: issue one read per cycle, consume the data in the next cycle
  assign issue  = ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) && (cnt_r != CNT_END);
  assign raddr  = {set_r, cnt_r[WAY_BITS-1:0]};
  assign row_ok = row_valid_r[set_r];

  // An untouched set reads as invalid ways ranked by way index
  assign meta_rd  = meta_t'(meta_rbits);
  assign meta_eff = row_ok ? meta_rd : meta_t'{valid: 1'b0, rank: rd_way_r};

  // Target of the promote: hit way, or least recent way on a miss
  assign tgt_way  = found_r ? hit_way_r : vic_way_r;
  assign tgt_rank = found_r ? hit_rank_r : RANK_LRU;
  assign evict    = !found_r && vic_valid_r;

  // Fill tag and value on a miss
  assign fill_we   = (state_r == ST_FILL) && !found_r;
  assign fill_addr = {set_r, vic_way_r};

  // Rank rewrite: promote target to rank 0, age ranks below its old rank
  assign meta_we    = (state_r == ST_UPDATE) && rd_vld_r;
  assign meta_waddr = {set_r, rd_way_r};
  always_comb begin
    if (rd_way_r == tgt_way) begin
      meta_wdata = '{valid: 1'b1, rank: '0};
    end else if (meta_eff.rank < tgt_rank) begin
      meta_wdata = '{valid: meta_eff.valid, rank: meta_eff.rank + 1'b1};
    end else begin
      meta_wdata = meta_eff;
    end
  end

  assign finish = (state_r == ST_DONE) && out_free;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_HASH;
      ST_HASH:   if (hash_stat.done) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == CNT_END) state_nxt = ST_FILL;
      ST_FILL:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (cnt_r == CNT_END) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: walk counter, read pipe flag, row flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      row_valid_r <= '0;
    end else begin
      rd_vld_r <= issue;
      if ((state_r == ST_HASH) || (state_r == ST_FILL)) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      // Mark the set written once every way has had its metadata rewritten
      if ((state_r == ST_UPDATE) && (cnt_r == CNT_END)) begin
        row_valid_r[set_r] <= 1'b1;
      end
    end
  end

  // Lookup payload and scan results
  always_ff @(posedge clk) begin
    rd_way_r <= cnt_r[WAY_BITS-1:0];
    if (in_fire) begin
      id_r   <= in_lookup_id;
      fill_r <= in_fill_handle;
    end
    if (state_r == ST_HASH) begin
      set_r   <= hash_stat.set_idx;
      found_r <= 1'b0;
    end
    if ((state_r == ST_SCAN) && rd_vld_r) begin
      // Compare one way per cycle
      if (meta_eff.valid && (tag_rdata == id_r)) begin
        found_r    <= 1'b1;
        hit_way_r  <= rd_way_r;
        hit_rank_r <= meta_eff.rank;
        handle_r   <= val_rdata;
      end
      // Remember the least recent way
      if (meta_eff.rank == RANK_LRU) begin
        vic_way_r   <= rd_way_r;
        vic_valid_r <= meta_eff.valid;
      end
    end
  end

  // Counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        hit_cnt_r   <= hit_cnt_r + COUNT_WIDTH'(found_r);
        miss_cnt_r  <= miss_cnt_r + COUNT_WIDTH'(!found_r);
        evict_cnt_r <= evict_cnt_r + COUNT_WIDTH'(evict);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit_r     <= found_r;
      out_handle_r  <= found_r ? handle_r : fill_r;
      out_evicted_r <= evict;
      out_set_r     <= SET_NUM_WIDTH'(set_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_value_handle = out_handle_r;
  assign out_evicted      = out_evicted_r;
  assign out_set_number   = out_set_r;
  assign out_hit_total    = hit_cnt_r;
  assign out_miss_total   = miss_cnt_r;
  assign out_evict_total  = evict_cnt_r;

  // A new result only ever comes out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  // Each finished lookup adds exactly one to hits plus misses
  a_one_count_per_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (COUNT_WIDTH'(hit_cnt_r + miss_cnt_r) ==
                COUNT_WIDTH'($past(hit_cnt_r) + $past(miss_cnt_r) + 1'b1)))
    else $error("hit and miss counters out of step");

  // An eviction is only reported on a miss
  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("eviction reported on a hit");

  // The set index holds from the end of the scan through the fill and rank rewrite
  a_set_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FILL) || (state_r == ST_UPDATE)) |-> $stable(set_r))
    else $error("set index changed during lookup");

  // The sequencer waits on the hash unit only while it is running
  a_hash_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH) |-> (hash_stat.busy || hash_stat.done))
    else $error("hash unit idle while sequencer waits on it");

endmodule

[dv/hashed_set_lru_id_cache_test.sv]
// ----------------------------------------------------------------------------
// hashed_set_lru_id_cache_test: self-checking bench for the LRU id cache
// A shadow copy of the 64-set, 16-way cache (tags, handles, valid flags,
// recency ranks and the three totals) predicts every lookup result. Directed
// lookups cover id zero on an empty set, the all-ones id, hits on the most
// recent and on an older way, and a full set that forces evictions. Random
// traffic then hammers hot sets with id pools larger than the set, so hits,
// refills and evictions interleave, mixed with scattered noise ids. The
// sender runs in bursts with gaps and the receiver stalls in several modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_set_lru_id_cache_test;
  import hslc_pkg::*;

  localparam int unsigned RANDOM_LOOKUPS = 500;
  localparam int unsigned SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic                     hit;
    logic [HANDLE_WIDTH-1:0]  handle;
    logic                     evicted;
    logic [SET_NUM_WIDTH-1:0] set_num;
    logic [COUNT_WIDTH-1:0]   hits;
    logic [COUNT_WIDTH-1:0]   misses;
    logic [COUNT_WIDTH-1:0]   evicts;
  } lookup_outcome_t;

  // Receiver stall modes
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_STARVED
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Shadow cache: predicts each lookup and holds the outcomes still in flight
  // --------------------------------------------------------------------------
  class cache_mirror;
    logic [ID_WIDTH-1:0]     tags    [ENTRY_COUNT];
    logic [HANDLE_WIDTH-1:0] handles [ENTRY_COUNT];
    bit                      live    [ENTRY_COUNT];
    logic [WAY_BITS-1:0]     age     [ENTRY_COUNT];
    logic [COUNT_WIDTH-1:0]  hit_count;
    logic [COUNT_WIDTH-1:0]  miss_count;
    logic [COUNT_WIDTH-1:0]  evict_count;
    lookup_outcome_t         pending_outcomes[$];
    int                      mismatches;
    int                      lookups_seen;

    function new();
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          live[s*WAY_COUNT + w] = 1'b0;
          age[s*WAY_COUNT + w]  = WAY_BITS'(w);
        end
      end
      hit_count    = '0;
      miss_count   = '0;
      evict_count  = '0;
      mismatches   = 0;
      lookups_seen = 0;
    endfunction

    // Shift-add hash h = 33*h + byte from zero over the id bytes, low byte first, reduced to a set
    static function logic [SET_BITS-1:0] set_of(logic [ID_WIDTH-1:0] id);
      logic [31:0] h;
      h = '0;
      for (int i = 0; i < ID_BYTES; i++) begin
        h = h * 32'd33 + 32'(id[i*BYTE_WIDTH +: BYTE_WIDTH]);
      end
      return SET_BITS'(h % SET_COUNT);
    endfunction

    function void apply_lookup(logic [ID_WIDTH-1:0] id, logic [HANDLE_WIDTH-1:0] fill);
      int                  base;
      int                  way;
      bit                  found;
      logic [WAY_BITS-1:0] old_rank;
      lookup_outcome_t     o;
      o         = '0;
      o.set_num = set_of(id);
      base      = int'(o.set_num) * WAY_COUNT;
      found     = 1'b0;
      way       = 0;
      // only valid ways may match
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (!found && live[base + w] && tags[base + w] == id) begin
          found = 1'b1;
          way   = w;
        end
      end
      if (found) begin
        o.handle  = handles[base + way];
        hit_count = hit_count + 1'b1;
      end else begin
        // refill the least recent way
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (age[base + w] == WAY_COUNT - 1) way = w;
        end
        if (live[base + way]) begin
          o.evicted   = 1'b1;
          evict_count = evict_count + 1'b1;
        end
        tags[base + way]    = id;
        handles[base + way] = fill;
        live[base + way]    = 1'b1;
        miss_count          = miss_count + 1'b1;
        o.handle            = fill;
      end
      // promote the touched way to most recent
      old_rank = age[base + way];
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (age[base + w] < old_rank) age[base + w] = age[base + w] + 1'b1;
      end
      age[base + way] = '0;
      o.hit    = found;
      o.hits   = hit_count;
      o.misses = miss_count;
      o.evicts = evict_count;
      pending_outcomes.push_back(o);
      lookups_seen++;
    endfunction

    function void note_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void compare_outcome(lookup_outcome_t got);
      lookup_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = pending_outcomes.pop_front();
      note_field("hit", want.hit, got.hit);
      note_field("value_handle", want.handle, got.handle);
      note_field("evicted", want.evicted, got.evicted);
      note_field("set_number", want.set_num, got.set_num);
      note_field("hit_total", want.hits, got.hits);
      note_field("miss_total", want.misses, got.misses);
      note_field("evict_total", want.evicts, got.evicts);
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [ID_WIDTH-1:0]      in_lookup_id;
  logic [HANDLE_WIDTH-1:0]  in_fill_handle;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_hit;
  logic [HANDLE_WIDTH-1:0]  out_value_handle;
  logic                     out_evicted;
  logic [SET_NUM_WIDTH-1:0] out_set_number;
  logic [COUNT_WIDTH-1:0]   out_hit_total;
  logic [COUNT_WIDTH-1:0]   out_miss_total;
  logic [COUNT_WIDTH-1:0]   out_evict_total;

  cache_mirror mirror;
  int          burst_left;

  hashed_set_lru_id_cache uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_lookup_id     (in_lookup_id),
    .in_fill_handle   (in_fill_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_value_handle (out_value_handle),
    .out_evicted      (out_evicted),
    .out_set_number   (out_set_number),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .out_evict_total  (out_evict_total)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: switch between stall modes for random spans
  initial begin
    rx_mode_t mode;
    int       span;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:    out_ready = 1'b1;
          RX_RANDOM:  out_ready = 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ready = ($urandom_range(0, 9) == 0);
          default:    out_ready = ($urandom_range(0, 99) < 3);
        endcase
      end
    end
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mirror.compare_outcome({out_hit, out_value_handle, out_evicted, out_set_number,
                              out_hit_total, out_miss_total, out_evict_total});
    end
  end

  // Random id that lands in the given set
  function automatic logic [ID_WIDTH-1:0] id_in_set(logic [SET_BITS-1:0] set_idx);
    logic [ID_WIDTH-1:0] id;
    do begin
      id = {$urandom, $urandom};
    end while (cache_mirror::set_of(id) != set_idx);
    return id;
  endfunction

  // Fill handle with the extremes mixed in
  function automatic logic [HANDLE_WIDTH-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Offer one lookup transaction; pace the sender in bursts. Call at negedge.
  task automatic present_lookup(logic [ID_WIDTH-1:0] id, logic [HANDLE_WIDTH-1:0] fill);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 5);
        2:       gap = $urandom_range(6, 50);
        default: gap = $urandom_range(40, 90);
      endcase
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    in_valid       = 1'b1;
    in_lookup_id   = id;
    in_fill_handle = fill;
    do @(posedge clk); while (!in_ready);
    mirror.apply_lookup(id, fill);
    burst_left--;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic drain_outcomes();
    in_valid = 1'b0;
    while (mirror.pending_outcomes.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [ID_WIDTH-1:0] pool [24];
    logic [ID_WIDTH-1:0] zero_set_ids [WAY_COUNT];
    logic [SET_BITS-1:0] hot_set;
    int                  pool_size;
    int                  seq_len;
    int                  pick;
    int                  sent;
    int                  since_drain;

    mirror         = new();
    burst_left     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_lookup_id   = '0;
    in_fill_handle = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: id zero on an empty cache must miss, then hit on the MRU way
    present_lookup('0, '0);
    present_lookup('0, '1);
    present_lookup('1, '1);
    present_lookup('1, 32'h1234_5678);
    // hit id zero again; the all-ones id hashes to another set, so id zero is still most recent
    present_lookup('0, 32'h0F0F_0F0F);
    // overfill the set of id zero to force evictions
    for (int k = 0; k < WAY_COUNT; k++) begin
      zero_set_ids[k] = id_in_set(cache_mirror::set_of('0));
      present_lookup(zero_set_ids[k], pick_handle());
    end
    present_lookup('0, 32'hA5A5_A5A5);
    present_lookup(zero_set_ids[WAY_COUNT-1], '0);
    drain_outcomes();

    // Random: hot sets with id pools bigger than the set, plus noise
    sent        = 0;
    since_drain = 0;
    while (sent < RANDOM_LOOKUPS) begin
      if ($urandom_range(0, 99) < 15) begin
        present_lookup({$urandom, $urandom}, pick_handle());
        sent++;
        since_drain++;
      end else begin
        hot_set   = SET_BITS'($urandom_range(0, SET_COUNT - 1));
        pool_size = $urandom_range(WAY_COUNT + 1, 24);
        for (int k = 0; k < pool_size; k++) pool[k] = id_in_set(hot_set);
        seq_len = $urandom_range(20, 40);
        pick    = 0;
        for (int k = 0; k < seq_len; k++) begin
          // repeat the last id now and then for hits on the MRU way
          if ($urandom_range(0, 4) != 0) pick = $urandom_range(0, pool_size - 1);
          present_lookup(pool[pick], pick_handle());
        end
        sent        += seq_len;
        since_drain += seq_len;
      end
      if (since_drain > 150) begin
        drain_outcomes();
        since_drain = 0;
      end
    end

    // Let the last results come out, then allow stray ones to show up
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d lookups over hot and scattered sets: %0d hits, %0d misses, %0d evictions.",
             mirror.lookups_seen, mirror.hit_count, mirror.miss_count, mirror.evict_count);
    if (mirror.mismatches == 0 && mirror.pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/hslc_pkg.sv
sv/hslc_ram.sv
sv/hslc_hash.sv
sv/hashed_set_lru_id_cache.sv
dv/hashed_set_lru_id_cache_test.sv
